### hw/rtl/fhpc_pkg.sv
// ----------------------------------------------------------------------------
// fhpc_pkg
// Types, codes and constants shared by the frame header parse and check block.
// ----------------------------------------------------------------------------
package fhpc_pkg;

	localparam logic [31:0] BASE_FRAME_LIMIT = 32'd1500;

	localparam int CFG_INDEX_W = 3;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_GENERAL_LIMIT = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_CONTROL_LIMIT = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_RPC_LIMIT     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_AUDIO_LIMIT   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_VIDEO_LIMIT   = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_HIGHEST_VER   = 3'd5;

	// service codes
	localparam logic [7:0] SVC_CONTROL = 8'h00;
	localparam logic [7:0] SVC_RPC     = 8'h07;
	localparam logic [7:0] SVC_AUDIO   = 8'h0A;
	localparam logic [7:0] SVC_VIDEO   = 8'h0B;
	localparam logic [7:0] SVC_BULK    = 8'h0F;

	// frame kinds
	localparam logic [2:0] KIND_CONTROL     = 3'd0;
	localparam logic [2:0] KIND_SINGLE      = 3'd1;
	localparam logic [2:0] KIND_FIRST       = 3'd2;
	localparam logic [2:0] KIND_CONSECUTIVE = 3'd3;

	// versions
	localparam logic [3:0] VER_1 = 4'd1;
	localparam logic [3:0] VER_2 = 4'd2;
	localparam logic [3:0] VER_3 = 4'd3;
	localparam logic [3:0] VER_4 = 4'd4;
	localparam logic [3:0] VER_5 = 4'd5;

	// control frame info ranges
	localparam logic [7:0] CTRL_INFO_LOW_MAX  = 8'h09;
	localparam logic [7:0] CTRL_INFO_HIGH_MIN = 8'hFD;

	localparam logic [3:0] MIN_HDR_BYTES  = 4'd8;
	localparam logic [3:0] FULL_HDR_BYTES = 4'd12;

	typedef struct packed {
		logic [7:0]  lead_byte;
		logic [7:0]  service_byte;
		logic [7:0]  info_byte;
		logic [7:0]  session_byte;
		logic [31:0] size_word;
		logic [31:0] id_word;
		logic [3:0]  bytes_present;
	} fhpc_req_t;

	typedef struct packed {
		logic [3:0]  version;
		logic        protected_res;
		logic [2:0]  frame_kind;
		logic [7:0]  service_out;
		logic [7:0]  info_out;
		logic [7:0]  session_out;
		logic [31:0] payload_length;
		logic [31:0] message_number;
		logic [31:0] payload_limit;
		logic        accepted;
	} fhpc_res_t;

	typedef struct packed {
		logic [31:0] general_limit;
		logic [31:0] control_limit;
		logic [31:0] rpc_limit;
		logic [31:0] audio_limit;
		logic [31:0] video_limit;
		logic [3:0]  highest_version;
	} fhpc_cfg_t;

	// decoded header handed from the decode stage to the check stage
	typedef struct packed {
		logic [3:0]  version;
		logic        protected_res;
		logic [2:0]  frame_kind;
		logic [7:0]  service;
		logic [7:0]  info;
		logic [7:0]  session;
		logic [31:0] size;
		logic [31:0] msg;
		logic [31:0] limit;
		logic        short_hdr;
		logic        pre_ok;
	} fhpc_dec_t;

endpackage

### hw/rtl/fhpc_decode.sv
// ----------------------------------------------------------------------------
// fhpc_decode
// Input register and field decode: version, kind, message id, limit select
// and the checks that need no size compare.
// ----------------------------------------------------------------------------
module fhpc_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  fhpc_pkg::fhpc_req_t req,
	input  fhpc_pkg::fhpc_cfg_t cfg,
	output logic                valid_s2,
	output fhpc_pkg::fhpc_dec_t dec_s2
);

	logic                valid_s1;
	fhpc_pkg::fhpc_req_t req_s1;
	fhpc_pkg::fhpc_dec_t dec;

	logic [3:0]  ver;
	logic [2:0]  kind;
	logic [7:0]  svc;
	logic [7:0]  info;
	logic [31:0] v5_limit;
	logic [31:0] v34_limit;
	logic        ver_ok;
	logic        svc_ok;
	logic        info_ok;
	logic        size_zero_bad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			req_s1 <= req;
		end
	end

	assign ver  = req_s1.lead_byte[7:4];
	assign kind = req_s1.lead_byte[2:0];
	assign svc  = req_s1.service_byte;
	assign info = req_s1.info_byte;

	assign v34_limit = (cfg.general_limit > fhpc_pkg::BASE_FRAME_LIMIT) ?
		cfg.general_limit : fhpc_pkg::BASE_FRAME_LIMIT;

	// per-service limit; zero register falls back to the general limit
	always_comb begin
		unique case (svc)
			fhpc_pkg::SVC_CONTROL:
				v5_limit = (cfg.control_limit == '0) ? cfg.general_limit : cfg.control_limit;
			fhpc_pkg::SVC_RPC, fhpc_pkg::SVC_BULK:
				v5_limit = (cfg.rpc_limit == '0) ? cfg.general_limit : cfg.rpc_limit;
			fhpc_pkg::SVC_AUDIO:
				v5_limit = (cfg.audio_limit == '0) ? cfg.general_limit : cfg.audio_limit;
			fhpc_pkg::SVC_VIDEO:
				v5_limit = (cfg.video_limit == '0) ? cfg.general_limit : cfg.video_limit;
			default:
				v5_limit = '0;
		endcase
	end

	assign svc_ok = (svc == fhpc_pkg::SVC_CONTROL) || (svc == fhpc_pkg::SVC_RPC) ||
		(svc == fhpc_pkg::SVC_AUDIO) || (svc == fhpc_pkg::SVC_VIDEO) ||
		(svc == fhpc_pkg::SVC_BULK);

	always_comb begin
		case (kind)
			fhpc_pkg::KIND_CONTROL:
				info_ok = (info <= fhpc_pkg::CTRL_INFO_LOW_MAX) ||
					(info >= fhpc_pkg::CTRL_INFO_HIGH_MIN);
			fhpc_pkg::KIND_SINGLE, fhpc_pkg::KIND_FIRST:
				info_ok = (info == '0);
			fhpc_pkg::KIND_CONSECUTIVE:
				info_ok = 1'b1;
			default:
				info_ok = 1'b0;
		endcase
	end

	assign size_zero_bad = ((kind == fhpc_pkg::KIND_SINGLE) ||
		(kind == fhpc_pkg::KIND_CONSECUTIVE)) && (req_s1.size_word == '0);

	always_comb begin
		dec               = '0;
		dec.version       = ver;
		dec.protected_res = req_s1.lead_byte[3];
		dec.frame_kind    = kind;
		dec.service       = svc;
		dec.info          = info;
		dec.session       = req_s1.session_byte;
		dec.size          = req_s1.size_word;
		dec.short_hdr     = (req_s1.bytes_present < fhpc_pkg::MIN_HDR_BYTES);
		ver_ok            = 1'b1;
		unique case (ver)
			fhpc_pkg::VER_1, fhpc_pkg::VER_2: dec.limit = fhpc_pkg::BASE_FRAME_LIMIT;
			fhpc_pkg::VER_3, fhpc_pkg::VER_4: dec.limit = v34_limit;
			fhpc_pkg::VER_5:                  dec.limit = v5_limit;
			default: begin
				dec.limit = '0;
				ver_ok    = 1'b0;
			end
		endcase
		if ((ver >= fhpc_pkg::VER_2) && (ver <= fhpc_pkg::VER_5) &&
				(req_s1.bytes_present >= fhpc_pkg::FULL_HDR_BYTES)) begin
			dec.msg = req_s1.id_word;
		end
		dec.pre_ok = ver_ok && (ver <= cfg.highest_version) && svc_ok && info_ok &&
			!size_zero_bad;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			dec_s2 <= dec;
		end
	end

endmodule

### hw/rtl/fhpc_check.sv
// ----------------------------------------------------------------------------
// fhpc_check
// Size against limit, message id check, short header blanking and the
// result register.
// ----------------------------------------------------------------------------
module fhpc_check (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s2,
	input  fhpc_pkg::fhpc_dec_t dec_s2,
	output logic                valid_s3,
	output fhpc_pkg::fhpc_res_t res_s3
);

	fhpc_pkg::fhpc_res_t res;
	logic                size_ok;
	logic                msg_ok;

	assign size_ok = (dec_s2.size <= dec_s2.limit);
	assign msg_ok  = (dec_s2.msg != '0) || (dec_s2.frame_kind == fhpc_pkg::KIND_CONTROL) ||
		(dec_s2.version == fhpc_pkg::VER_1);

	always_comb begin
		res = '0;
		if (!dec_s2.short_hdr) begin
			res.version        = dec_s2.version;
			res.protected_res  = dec_s2.protected_res;
			res.frame_kind     = dec_s2.frame_kind;
			res.service_out    = dec_s2.service;
			res.info_out       = dec_s2.info;
			res.session_out    = dec_s2.session;
			res.payload_length = dec_s2.size;
			res.message_number = dec_s2.msg;
			res.payload_limit  = dec_s2.limit;
			res.accepted       = dec_s2.pre_ok && size_ok && msg_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			res_s3 <= res;
		end
	end

	a_valid_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 == $past(valid_s2))
		else $error("result valid does not follow check stage valid");

	a_size_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && res_s3.accepted) |-> (res_s3.payload_length <= res_s3.payload_limit))
		else $error("accepted header exceeds its payload limit");

	a_msg_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && res_s3.accepted) |-> ((res_s3.message_number != '0) ||
		(res_s3.frame_kind == fhpc_pkg::KIND_CONTROL) || (res_s3.version == fhpc_pkg::VER_1)))
		else $error("accepted header lacks a message id");

	a_version_range: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && res_s3.accepted) |-> ((res_s3.version >= fhpc_pkg::VER_1) &&
		(res_s3.version <= fhpc_pkg::VER_5)))
		else $error("accepted header has an unknown version");

endmodule

### hw/rtl/frame_header_parse_and_check.sv
// ----------------------------------------------------------------------------
// frame_header_parse_and_check
// Splits a frame header into its fields and checks it against the limits.
// ----------------------------------------------------------------------------
// One header request is taken in every clock cycle; busy never goes high.
// Each request gives exactly one result, shown with done for one cycle, in
// request order. The result passes through three register stages: input
// capture, field decode with limit select, and the size compare feeding the
// result register. Results cannot be held off.
// Configuration registers are written through cfg_we / cfg_index / cfg_data
// and must only change while no request is in flight.
module frame_header_parse_and_check (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  fhpc_pkg::fhpc_req_t                 req,
	output logic                                done,
	output fhpc_pkg::fhpc_res_t                 result,
	input  logic                                cfg_we,
	input  logic [fhpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [31:0]                         cfg_data
);

	fhpc_pkg::fhpc_cfg_t cfg_q;
	logic                valid_s2;
	fhpc_pkg::fhpc_dec_t dec_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.general_limit   <= '1;
			cfg_q.control_limit   <= '0;
			cfg_q.rpc_limit       <= '0;
			cfg_q.audio_limit     <= '0;
			cfg_q.video_limit     <= '0;
			cfg_q.highest_version <= fhpc_pkg::VER_5;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fhpc_pkg::CFG_GENERAL_LIMIT: cfg_q.general_limit   <= cfg_data;
				fhpc_pkg::CFG_CONTROL_LIMIT: cfg_q.control_limit   <= cfg_data;
				fhpc_pkg::CFG_RPC_LIMIT:     cfg_q.rpc_limit       <= cfg_data;
				fhpc_pkg::CFG_AUDIO_LIMIT:   cfg_q.audio_limit     <= cfg_data;
				fhpc_pkg::CFG_VIDEO_LIMIT:   cfg_q.video_limit     <= cfg_data;
				fhpc_pkg::CFG_HIGHEST_VER:   cfg_q.highest_version <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	fhpc_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.req      (req),
		.cfg      (cfg_q),
		.valid_s2 (valid_s2),
		.dec_s2   (dec_s2)
	);

	fhpc_check u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.dec_s2   (dec_s2),
		.valid_s3 (done),
		.res_s3   (result)
	);

endmodule
